// File: rtl/usb_host_channel_tracker_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the host channel tracker
// Guarded assertion wrappers used by the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef USB_HOST_CHANNEL_TRACKER_MACROS_SVH
`define USB_HOST_CHANNEL_TRACKER_MACROS_SVH
`ifndef ASSERT_OFF
`define UHT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UHT_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define UHT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define UHT_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/uhct_pkg.sv
// ----------------------------------------------------------------------------
// Host channel tracker package
// Shared widths, codes, item types and controller/datapath control types.
// ----------------------------------------------------------------------------
package uhct_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_W          = 4;
    localparam int LEN_W         = 19;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    localparam logic [1:0] CMD_INIT   = 2'd0;
    localparam logic [1:0] CMD_SUBMIT = 2'd1;
    localparam logic [1:0] CMD_IRQ    = 2'd2;
    localparam logic [1:0] CMD_RXPKT  = 2'd3;

    localparam logic [1:0] T_CTRL = 2'd0;
    localparam logic [1:0] T_ISOC = 2'd1;
    localparam logic [1:0] T_BULK = 2'd2;
    localparam logic [1:0] T_INTR = 2'd3;

    localparam logic [1:0] PID_DATA0 = 2'd0;
    localparam logic [1:0] PID_DATA1 = 2'd2;
    localparam logic [1:0] PID_SETUP = 2'd3;

    localparam logic [2:0] U_IDLE  = 3'd0;
    localparam logic [2:0] U_DONE  = 3'd1;
    localparam logic [2:0] U_NRDY  = 3'd2;
    localparam logic [2:0] U_ERR   = 3'd3;
    localparam logic [2:0] U_STALL = 3'd4;

    localparam logic [2:0] P_IDLE  = 3'd0;
    localparam logic [2:0] P_XFRC  = 3'd1;
    localparam logic [2:0] P_STALL = 3'd2;
    localparam logic [2:0] P_DTERR = 3'd3;
    localparam logic [2:0] P_XACT  = 3'd4;
    localparam logic [2:0] P_NAK   = 3'd5;
    localparam logic [2:0] P_NYET  = 3'd6;

    localparam int F_AHBERR = 0;
    localparam int F_ACK    = 1;
    localparam int F_STALL  = 2;
    localparam int F_DTERR  = 3;
    localparam int F_FRMOR  = 4;
    localparam int F_XFRC   = 5;
    localparam int F_CHH    = 6;
    localparam int F_TXERR  = 7;
    localparam int F_NAK    = 8;
    localparam int F_NYET   = 9;

    typedef struct packed {
        logic [1:0]       command;
        logic [CH_W-1:0]  channel;
        logic [1:0]       ep_type;
        logic             dir_is_in;
        logic             data_token;
        logic [LEN_W-1:0] xfer_length;
        logic             ping_request;
        logic [9:0]       int_flags;
        logic [LEN_W-1:0] remaining_size;
        logic [10:0]      packet_bytes;
        logic [9:0]       packets_left;
        logic             buffer_present;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]  out_channel;
        logic [1:0]       token_pid;
        logic [2:0]       urb_status;
        logic [2:0]       chan_status;
        logic             halt_request;
        logic             reenable_request;
        logic             urb_notify;
        logic [LEN_W-1:0] done_bytes;
        logic             toggle_in_now;
        logic             toggle_out_now;
        logic             odd_frame_set;
        logic             read_packet;
    } result_t;

    typedef struct packed {
        logic [1:0]       ep_type;
        logic             dir_in;
        logic             tog_in;
        logic             tog_out;
        logic [2:0]       err;
        logic [2:0]       urb;
        logic [2:0]       phase;
        logic             ping;
        logic [LEN_W-1:0] length;
        logic [LEN_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic capture;
        logic update;
    } dp_cmd_t;

    typedef struct packed {
        logic busy;
    } dp_status_t;

endpackage

// File: rtl/uhct_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready channel interface
// Carries one payload with valid and ready between source and sink.
// ----------------------------------------------------------------------------
interface uhct_stream_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/uhct_datapath.sv
// ----------------------------------------------------------------------------
// Host channel tracker datapath
// Channel table, item register and the read-modify-write update logic.
// ----------------------------------------------------------------------------
module uhct_datapath
    import uhct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       dma_mode,
    input  dp_cmd_t    cmd,
    input  item_t      item_in,
    output dp_status_t status,
    output result_t    result
);

    entry_t  table_reg [NUM_CHANNELS];
    item_t   item_reg;
    result_t result_reg;
    entry_t  e;
    entry_t  n;
    result_t r;
    logic [9:0] f;
    logic [9:0] g;
    logic [LEN_W:0] sum;
    logic in_range;

    assign in_range = ({1'b0, item_reg.channel} < (CH_W+1)'(NUM_CHANNELS));
    assign e = table_reg[item_reg.channel[CH_W-1:0]];
    assign status.busy = 1'b0;
    assign result = result_reg;

    always_comb
    begin
        n = e;
        r = '0;
        f = item_reg.int_flags;
        g = f;
        sum = {1'b0, e.count} + {{(LEN_W-11){1'b0}}, 1'b0, item_reg.packet_bytes};
        r.out_channel = item_reg.channel;
        case (item_reg.command)
            CMD_INIT:
            begin
                n.ep_type = item_reg.ep_type;
                n.dir_in = item_reg.dir_is_in;
                n.tog_in = 1'b0;
                n.tog_out = 1'b0;
                n.err = 3'd0;
                n.urb = U_IDLE;
                n.phase = P_IDLE;
            end
            CMD_SUBMIT:
            begin
                n.dir_in = item_reg.dir_is_in;
                n.ep_type = item_reg.ep_type;
                r.token_pid = item_reg.data_token ? PID_DATA1 : PID_SETUP;
                case (item_reg.ep_type)
                    T_CTRL:
                    begin
                        if (item_reg.data_token && !item_reg.dir_is_in)
                        begin
                            if (item_reg.xfer_length == '0)
                                n.tog_out = 1'b1;
                            r.token_pid = n.tog_out ? PID_DATA1 : PID_DATA0;
                            if (e.urb != U_NRDY)
                                n.ping = item_reg.ping_request;
                        end
                    end
                    T_BULK:
                    begin
                        if (!item_reg.dir_is_in)
                        begin
                            r.token_pid = e.tog_out ? PID_DATA1 : PID_DATA0;
                            if (e.urb != U_NRDY)
                                n.ping = item_reg.ping_request;
                        end
                        else
                            r.token_pid = e.tog_in ? PID_DATA1 : PID_DATA0;
                    end
                    T_INTR:
                        r.token_pid = (item_reg.dir_is_in ? e.tog_in : e.tog_out)
                                     ? PID_DATA1 : PID_DATA0;
                    default:
                        r.token_pid = PID_DATA0;
                endcase
                n.length = item_reg.xfer_length;
                n.urb = U_IDLE;
                n.count = '0;
                n.phase = P_IDLE;
            end
            CMD_IRQ:
            begin
                if (e.dir_in)
                begin
                    if (f[F_AHBERR] || f[F_ACK])
                    begin
                    end
                    else if (f[F_STALL])
                    begin
                        n.phase = P_STALL;
                        r.halt_request = 1'b1;
                        g[F_NAK] = 1'b0;
                    end
                    else if (f[F_DTERR])
                    begin
                        n.phase = P_DTERR;
                        r.halt_request = 1'b1;
                        g[F_NAK] = 1'b0;
                    end
                    if (g[F_FRMOR])
                        r.halt_request = 1'b1;
                    else if (g[F_XFRC])
                    begin
                        if (dma_mode)
                            n.count = (item_reg.remaining_size > e.length) ? '0
                                      : e.length - item_reg.remaining_size;
                        n.phase = P_XFRC;
                        n.err = 3'd0;
                        if (e.ep_type == T_CTRL || e.ep_type == T_BULK)
                            r.halt_request = 1'b1;
                        else if (e.ep_type == T_INTR)
                        begin
                            r.odd_frame_set = 1'b1;
                            n.urb = U_DONE;
                            r.urb_notify = 1'b1;
                        end
                        n.tog_in = ~e.tog_in;
                    end
                    else if (g[F_CHH])
                    begin
                        if (n.phase == P_XFRC)
                            n.urb = U_DONE;
                        else if (n.phase == P_STALL)
                            n.urb = U_STALL;
                        else if (n.phase == P_XACT || n.phase == P_DTERR)
                        begin
                            if (e.err > 3'd3)
                            begin
                                n.err = 3'd0;
                                n.urb = U_ERR;
                            end
                            else
                            begin
                                n.err = e.err + 3'd1;
                                n.urb = U_NRDY;
                            end
                            r.reenable_request = 1'b1;
                        end
                        r.urb_notify = 1'b1;
                    end
                    else if (g[F_TXERR])
                    begin
                        if (e.err != 3'd7)
                            n.err = e.err + 3'd1;
                        n.phase = P_XACT;
                        r.halt_request = 1'b1;
                    end
                    else if (g[F_NAK])
                    begin
                        if (e.ep_type == T_INTR)
                            r.halt_request = 1'b1;
                        else if (e.ep_type == T_CTRL || e.ep_type == T_BULK)
                            r.reenable_request = 1'b1;
                        n.phase = P_NAK;
                    end
                end
                else
                begin
                    if (f[F_AHBERR])
                    begin
                    end
                    else if (f[F_ACK])
                    begin
                        if (e.ping)
                        begin
                            n.phase = P_NYET;
                            r.halt_request = 1'b1;
                            n.urb = U_NRDY;
                        end
                    end
                    else if (f[F_NYET])
                    begin
                        n.phase = P_NYET;
                        n.err = 3'd0;
                        r.halt_request = 1'b1;
                    end
                    else if (f[F_FRMOR])
                        r.halt_request = 1'b1;
                    else if (f[F_XFRC])
                    begin
                        n.err = 3'd0;
                        r.halt_request = 1'b1;
                        n.phase = P_XFRC;
                    end
                    else if (f[F_STALL])
                    begin
                        r.halt_request = 1'b1;
                        n.phase = P_STALL;
                    end
                    else if (f[F_NAK])
                    begin
                        n.err = 3'd0;
                        r.halt_request = 1'b1;
                        n.phase = P_NAK;
                    end
                    else if (f[F_TXERR])
                    begin
                        r.halt_request = 1'b1;
                        n.phase = P_XACT;
                    end
                    else if (f[F_DTERR])
                    begin
                        r.halt_request = 1'b1;
                        n.phase = P_DTERR;
                    end
                    else if (f[F_CHH])
                    begin
                        if (e.phase == P_XFRC)
                        begin
                            n.urb = U_DONE;
                            if (e.ep_type == T_BULK)
                                n.tog_out = ~e.tog_out;
                        end
                        else if (e.phase == P_NAK)
                            n.urb = U_NRDY;
                        else if (e.phase == P_NYET)
                        begin
                            n.urb = U_NRDY;
                            n.ping = 1'b0;
                        end
                        else if (e.phase == P_STALL)
                            n.urb = U_STALL;
                        else if (e.phase == P_XACT || e.phase == P_DTERR)
                        begin
                            if (e.err > 3'd3)
                            begin
                                n.err = 3'd0;
                                n.urb = U_ERR;
                            end
                            else
                            begin
                                n.err = e.err + 3'd1;
                                n.urb = U_NRDY;
                            end
                            r.reenable_request = 1'b1;
                        end
                        r.urb_notify = 1'b1;
                    end
                end
            end
            CMD_RXPKT:
            begin
                if (item_reg.packet_bytes != '0 && item_reg.buffer_present)
                begin
                    r.read_packet = 1'b1;
                    n.count = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
                    if (item_reg.packets_left != '0)
                    begin
                        r.reenable_request = 1'b1;
                        n.tog_in = ~e.tog_in;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.urb_status = n.urb;
        r.chan_status = n.phase;
        r.done_bytes = n.count;
        r.toggle_in_now = n.tog_in;
        r.toggle_out_now = n.tog_out;
        if (!in_range)
        begin
            r = '0;
            r.out_channel = item_reg.channel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item_in;
        if (cmd.update)
            result_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
                table_reg[i] <= '0;
        end
        else if (cmd.update && in_range)
            table_reg[item_reg.channel[CH_W-1:0]] <= n;
    end

endmodule

// File: rtl/uhct_ctrl.sv
// ----------------------------------------------------------------------------
// Host channel tracker controller
// Sequences capture, table update and result transfer for one item.
// ----------------------------------------------------------------------------
module uhct_ctrl
    import uhct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_OUT} state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign cmd.capture = in_valid && in_ready;
    assign cmd.update = (state_reg == ST_EXEC) && !status.busy;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_EXEC;
            ST_EXEC: if (!status.busy) state_next = ST_OUT;
            ST_OUT:  if (out_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/usb_host_channel_tracker.sv
// ----------------------------------------------------------------------------
// USB host channel tracker
// An item is first registered, then its channel table entry goes through a
// read-modify-write and the result is offered on the output channel; the
// next item is taken once the result transfer completes, so no new item is
// accepted while one is in flight. The table resets to zero at once, with
// no sweep.
`include "usb_host_channel_tracker_macros.svh"
module usb_host_channel_tracker
    import uhct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic cfg_wdata,
    uhct_stream_if.sink   in_ch,
    uhct_stream_if.source out_ch
);

    logic       dma_mode_reg;
    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dma_mode_reg <= 1'b0;
        else if (cfg_we)
            dma_mode_reg <= cfg_wdata;
    end

    uhct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    uhct_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .dma_mode (dma_mode_reg),
        .cmd      (cmd),
        .item_in  (in_ch.payload),
        .status   (status),
        .result   (result)
    );

    assign out_ch.payload = result;

    `UHT_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_ch.ready && out_ch.valid, "ready while result pending")
    `UHT_ASSERT_IMPL(a_accept_to_out, clk, rst_n, (in_ch.valid && in_ch.ready) |-> ##2 out_ch.valid, "result not presented")
    `UHT_ASSERT_IMPL(a_out_release, clk, rst_n, (out_ch.valid && out_ch.ready) |=> in_ch.ready, "not released")

endmodule
